FILE: src/seb_pkg.sv
// Shared types and constants for the serial EEPROM block reader.
// Used by the channel interfaces and every module under src.
package seb_pkg;

  localparam int RETURN_BITS_DEF  = 68;
  localparam int DISCARD_BITS_DEF = 4;

  localparam int ADDR_W  = 14;
  localparam int COUNT_W = 11;
  localparam int DATA_W  = 64;
  localparam int KIND_W  = 2;
  localparam int APB_AW  = 3;
  localparam int QDEPTH  = 4;

  localparam logic [KIND_W-1:0] KIND_CMD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

  localparam logic [4:0] ABITS_SMALL = 5'd6;
  localparam logic [4:0] ABITS_LARGE = 5'd14;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BIT   = 1'b1;

  typedef enum logic [1:0] {
    JOB_ERR,
    JOB_FRAME,
    JOB_DATA,
    JOB_DATA_FRAME
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [DATA_W-1:0]  data;
    logic [ADDR_W-1:0]  addr;
    logic               last;
    logic               wide_addr;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              send_bit;
    logic [DATA_W-1:0] block_data;
    logic [ADDR_W-1:0] block_addr;
    logic              frame_end;
    logic              all_done;
  } beat_t;

  typedef enum logic {
    BK_JOB,
    BK_FRAME
  } bk_state_t;

endpackage

FILE: src/seb_ifs.sv
// Valid/ready channel interfaces for input items and result beats.
// Depends on seb_pkg for field widths.
interface seb_item_if;
  import seb_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [ADDR_W-1:0]  first_block;
  logic [COUNT_W-1:0] block_count;
  logic               bit_in;
  modport source(output valid, opcode, first_block, block_count, bit_in, input ready);
  modport sink(input valid, opcode, first_block, block_count, bit_in, output ready);
endinterface

interface seb_result_if;
  import seb_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              send_bit;
  logic [DATA_W-1:0] block_data;
  logic [ADDR_W-1:0] block_addr;
  logic              frame_end;
  logic              all_done;
  modport source(output valid, kind, send_bit, block_data, block_addr, frame_end, all_done,
                 input ready);
  modport sink(input valid, kind, send_bit, block_data, block_addr, frame_end, all_done,
               output ready);
endinterface

FILE: src/seb_front.sv
// Front end: accepts items, tracks the read state and the returned-bit shifter,
// and posts one job per item that causes results. Depends on seb_pkg, seb_ifs.
module seb_front #(
  parameter int RETURN_BITS  = seb_pkg::RETURN_BITS_DEF,
  parameter int DISCARD_BITS = seb_pkg::DISCARD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             large_part,
  seb_item_if.sink         item,
  input  seb_pkg::q_stat_t q_stat,
  output logic             push,
  output seb_pkg::job_t    push_job
);
  import seb_pkg::*;

  localparam int PosW = $clog2(RETURN_BITS + 1);

  logic               busy, busy_next;
  logic [PosW-1:0]    bit_position, bit_position_next, bp1;
  logic [DATA_W-1:0]  shift_word, shift_word_next, shifted;
  logic [ADDR_W-1:0]  current_block, current_block_next;
  logic [COUNT_W-1:0] blocks_left, blocks_left_next;
  logic               accept;

  assign item.ready = !q_stat.full;
  assign accept     = item.valid && item.ready;
  assign bp1        = bit_position + 1'b1;

  always_comb begin
    shifted = shift_word;
    if (bp1 > PosW'(DISCARD_BITS)) begin
      shifted = {shift_word[DATA_W-2:0], item.bit_in};
    end
  end

  always_comb begin
    busy_next          = busy;
    bit_position_next  = bit_position;
    shift_word_next    = shift_word;
    current_block_next = current_block;
    blocks_left_next   = blocks_left;
    push               = 1'b0;
    push_job.kind      = JOB_ERR;
    push_job.data      = '0;
    push_job.addr      = current_block;
    push_job.last      = 1'b0;
    push_job.wide_addr = large_part;
    if (accept) begin
      if (item.opcode == OP_START) begin
        if (busy) begin
          push = 1'b1;
        end else if (item.block_count != '0) begin
          busy_next          = 1'b1;
          current_block_next = item.first_block;
          blocks_left_next   = item.block_count;
          bit_position_next  = '0;
          shift_word_next    = '0;
          push               = 1'b1;
          push_job.kind      = JOB_FRAME;
          push_job.addr      = item.first_block;
        end
      end else if (!busy) begin
        push = 1'b1;
      end else if (bp1 < PosW'(RETURN_BITS)) begin
        bit_position_next = bp1;
        shift_word_next   = shifted;
      end else begin
        push               = 1'b1;
        push_job.kind      = (blocks_left == COUNT_W'(1)) ? JOB_DATA : JOB_DATA_FRAME;
        push_job.data      = shifted;
        push_job.last      = (blocks_left == COUNT_W'(1));
        blocks_left_next   = blocks_left - 1'b1;
        current_block_next = current_block + 1'b1;
        bit_position_next  = '0;
        shift_word_next    = '0;
        if (blocks_left == COUNT_W'(1)) begin
          busy_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      bit_position  <= '0;
      shift_word    <= '0;
      current_block <= '0;
      blocks_left   <= '0;
    end else begin
      busy          <= busy_next;
      bit_position  <= bit_position_next;
      shift_word    <= shift_word_next;
      current_block <= current_block_next;
      blocks_left   <= blocks_left_next;
    end
  end

endmodule

FILE: src/seb_queue.sv
// Short job queue between the front end and the frame sequencer.
// Depends on seb_pkg.
module seb_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  seb_pkg::job_t    push_job,
  input  logic             pop,
  output seb_pkg::job_t    head,
  output seb_pkg::q_stat_t q_stat
);
  import seb_pkg::*;

  localparam int PtrW = $clog2(QDEPTH);
  localparam int CntW = $clog2(QDEPTH + 1);

  job_t            slots [QDEPTH];
  logic [PtrW-1:0] wp, rp;
  logic [CntW-1:0] cnt;
  logic            do_push, do_pop;

  assign q_stat.full  = (cnt == CntW'(QDEPTH));
  assign q_stat.empty = (cnt == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slots[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PtrW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == PtrW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

FILE: src/seb_back.sv
// Back end: expands queued jobs into result beats, one per cycle unless
// result.ready stalls the registered output stage. Depends on seb_pkg and seb_ifs.
module seb_back (
  input  logic             clk,
  input  logic             rst,
  input  seb_pkg::job_t    head,
  input  seb_pkg::q_stat_t q_stat,
  output logic             pop,
  seb_result_if.source     result
);
  import seb_pkg::*;

  bk_state_t         state, state_next;
  logic [4:0]        idx, idx_next, abits, stop_idx, pos;
  logic [ADDR_W-1:0] faddr, faddr_next;
  logic              out_valid, out_load, emit;
  beat_t             res, beat;

  assign out_load = !out_valid || result.ready;
  assign abits    = head.wide_addr ? ABITS_LARGE : ABITS_SMALL;
  assign stop_idx = abits + 5'd2;
  assign pos      = abits + 5'd1 - idx;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_JOB: begin
        if (!q_stat.empty && out_load &&
            (head.kind == JOB_FRAME || head.kind == JOB_DATA_FRAME)) begin
          state_next = BK_FRAME;
        end
      end
      BK_FRAME: begin
        if (out_load && idx == stop_idx) begin
          state_next = BK_JOB;
        end
      end
      default: state_next = BK_JOB;
    endcase
  end

  always_comb begin
    emit       = 1'b0;
    pop        = 1'b0;
    idx_next   = idx;
    faddr_next = faddr;
    beat       = '0;
    unique case (state)
      BK_JOB: begin
        if (!q_stat.empty && out_load) begin
          unique case (head.kind)
            JOB_ERR: begin
              emit      = 1'b1;
              beat.kind = KIND_ERR;
              pop       = 1'b1;
            end
            JOB_FRAME: begin
              faddr_next = head.addr;
              idx_next   = '0;
            end
            JOB_DATA: begin
              emit            = 1'b1;
              beat.kind       = KIND_DATA;
              beat.block_data = head.data;
              beat.block_addr = head.addr;
              beat.all_done   = head.last;
              pop             = 1'b1;
            end
            JOB_DATA_FRAME: begin
              emit            = 1'b1;
              beat.kind       = KIND_DATA;
              beat.block_data = head.data;
              beat.block_addr = head.addr;
              beat.all_done   = head.last;
              faddr_next      = head.addr + 1'b1;
              idx_next        = '0;
            end
            default: pop = 1'b1;
          endcase
        end
      end
      BK_FRAME: begin
        if (out_load) begin
          emit            = 1'b1;
          beat.kind       = KIND_CMD;
          beat.block_addr = faddr;
          idx_next        = idx + 1'b1;
          priority if (idx < 5'd2) begin
            beat.send_bit = 1'b1;
          end else if (idx == stop_idx) begin
            beat.send_bit  = 1'b0;
            beat.frame_end = 1'b1;
            pop            = 1'b1;
            idx_next       = '0;
          end else begin
            beat.send_bit = faddr[pos[3:0]];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_JOB;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (out_load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    faddr <= faddr_next;
    if (out_load && emit) begin
      res <= beat;
    end
  end

  assign result.valid      = out_valid;
  assign result.kind       = res.kind;
  assign result.send_bit   = res.send_bit;
  assign result.block_data = res.block_data;
  assign result.block_addr = res.block_addr;
  assign result.frame_end  = res.frame_end;
  assign result.all_done   = res.all_done;

endmodule

FILE: src/serial_eeprom_block_reader.sv
// Serial EEPROM block reader: one returned bit or start item per cycle enters
// while the job queue has room; result beats leave one per cycle while
// result.ready is high. Beats pass the job queue and a registered output stage.
// A frame is 9 (small part) or 17 (large part) command beats from the sequencer,
// after a dispatch step when it does not follow a data beat; a 4-job queue
// decouples input from output. Synchronous reset clears all control state.
module serial_eeprom_block_reader #(
  parameter int RETURN_BITS  = seb_pkg::RETURN_BITS_DEF,
  parameter int DISCARD_BITS = seb_pkg::DISCARD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [seb_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  seb_item_if.sink                   item,
  seb_result_if.source               result
);
  import seb_pkg::*;

  logic    large_part;
  logic    push, pop;
  job_t    push_job, head;
  q_stat_t q_stat;

  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1] == 1'b0) ? {31'd0, large_part} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      large_part <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[APB_AW-1] == 1'b0) begin
      large_part <= pwdata[0];
    end
  end

  seb_front #(
    .RETURN_BITS (RETURN_BITS),
    .DISCARD_BITS(DISCARD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .large_part(large_part),
    .item      (item),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  seb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  seb_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .q_stat(q_stat),
    .pop   (pop),
    .result(result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("job queue written while full");

  a_frame_end_stop: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.frame_end |-> result.kind == KIND_CMD && !result.send_bit)
    else $error("frame end beat is not a zero command bit");

  a_done_on_data: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.all_done |-> result.kind == KIND_DATA)
    else $error("completion flag outside a data beat");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind == KIND_ERR |-> result.block_addr == '0 &&
    result.block_data == '0)
    else $error("error beat carries payload");

endmodule
